@@ design/walr_pkg.sv @@
package walr_pkg;
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS = 16;
  localparam int MAX_WIDTH = 62;
  localparam int CW = COORD_BITS + 1;
  localparam int YW = COORD_BITS + FRAC_BITS + 2;
  localparam int SW = FRAC_BITS + 2;
  localparam int QW = COORD_BITS + FRAC_BITS;
  localparam int DIVW = QW + 1;
  localparam int DCW = $clog2(DIVW + 1);
  localparam int OW = 14;

  typedef struct packed {
    logic start;
    logic [COORD_BITS-1:0] x0, y0, x1, y1;
    logic col_start;
    logic col_half;
    logic [1:0] col_sel;
    logic pix_first;
    logic pix_adv;
    logic pix_llast;
  } walr_cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_pix;
    logic done_flag;
  } walr_sts_t;

  localparam logic [1:0] SEL_FIRST = 2'd0;
  localparam logic [1:0] SEL_SECOND = 2'd1;
  localparam logic [1:0] SEL_INTERIOR = 2'd2;
endpackage

@@ design/wide_antialiased_line_raster.sv @@
// Channel | Direction | tdata (low bit up)                       | tuser
// s_axis  | in        | start_x, start_y, end_x, end_y           | kind
// m_axis  | out       | pixel_x, pixel_y, coverage, pixel_valid  | -
//                     | tlast = line_last, column_last in tdata[37]
// A start word is accepted, then the serial divider computes the gradient
// (29 shift steps and one rounding step), then the load state, then line_width+2 pixel
// words one per cycle while m_axis is ready. A next word is accepted, then the load state
// and line_width+2 pixel words; with no line active, it is accepted and gives one word.
// s_axis_tready is high only between items. Reset clears the control state; some datapath line registers are not reset.
// A stall on m_axis holds the current pixel word.
module wide_antialiased_line_raster (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // start_x, start_y, end_x, end_y
  input  logic        s_axis_tuser,  // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // pixel_x, pixel_y, coverage, pixel_valid, column_last, 0
  output logic        m_axis_tlast,  // line_last
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i
);
  import walr_pkg::*;

  walr_cmd_t cmd;
  walr_sts_t sts;
  logic [5:0] width_q;
  logic nul;
  logic [13:0] px, py;
  logic [7:0] cov;
  logic cl, ll;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= '0;
    end else if (cfg_we_i) begin
      width_q <= (cfg_wdata_i > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : cfg_wdata_i;
    end
  end

  walr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i({s_axis_tdata, s_axis_tuser}),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid), .out_null_o(nul),
    .sts_i(sts), .cmd_o(cmd)
  );

  walr_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .width_i(width_q), .sts_o(sts),
    .pixel_x_o(px), .pixel_y_o(py), .coverage_o(cov),
    .column_last_o(cl), .line_last_o(ll)
  );

  assign m_axis_tdata = nul ? 40'd0 : {2'b00, cl, 1'b1, cov, py, px};
  assign m_axis_tlast = nul ? 1'b0 : ll;
endmodule

@@ design/walr_datapath.sv @@
module walr_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  walr_pkg::walr_cmd_t cmd_i,
  input  logic [5:0]          width_i,
  output walr_pkg::walr_sts_t sts_o,
  output logic [13:0]         pixel_x_o,
  output logic [13:0]         pixel_y_o,
  output logic [7:0]          coverage_o,
  output logic                column_last_o,
  output logic                line_last_o
);
  import walr_pkg::*;

  logic steep_q, steep_d;
  logic [CW-1:0] colx_q, colx_d, finx_q, finx_d, x0_q, x0_d;
  logic signed [YW-1:0] yint_q, yint_d, endy_q, endy_d, y0f_q, y0f_d;
  logic signed [SW-1:0] slope_q, slope_d;
  logic neg_q, neg_d;
  logic [COORD_BITS-1:0] dx_q, dx_d;
  logic [DIVW-1:0] num_q, num_d;
  logic [COORD_BITS:0] rem_q, rem_d;
  logic [DCW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [CW-1:0] pcol_q, pcol_d;
  logic signed [OW-1:0] perp_q, perp_d;
  logic [7:0] lo_q, lo_d, hi_q, hi_d;
  logic [5:0] pidx_q, pidx_d;
  logic llast_q, llast_d;

  logic [COORD_BITS-1:0] ax0, ay0, ax1, ay1, sx0, sy0, sx1, sy1, adx, ady;
  logic stp;
  logic [COORD_BITS:0] trial;
  logic signed [YW-1:0] ysel;
  logic signed [YW-FRAC_BITS-1:0] base;
  logic [FRAC_BITS-1:0] f;
  logic [FRAC_BITS:0] onef;
  logic [FRAC_BITS+9:0] plo, phi;
  logic [5:0] w, off1;
  logic [SW-1:0] qmag;
  logic div_done, done_flag, last_pix;

  always_comb begin
    ax0 = cmd_i.x0; ay0 = cmd_i.y0; ax1 = cmd_i.x1; ay1 = cmd_i.y1;
    adx = (ax1 > ax0) ? ax1 - ax0 : ax0 - ax1;
    ady = (ay1 > ay0) ? ay1 - ay0 : ay0 - ay1;
    stp = ady > adx;
    sx0 = stp ? ay0 : ax0; sy0 = stp ? ax0 : ay0;
    sx1 = stp ? ay1 : ax1; sy1 = stp ? ax1 : ay1;
    if (sx0 > sx1) begin
      sx0 = sx1; sx1 = stp ? ay0 : ax0;
      sy0 = sy1; sy1 = stp ? ax0 : ay0;
    end
  end

  assign w = (width_i > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : width_i;
  assign off1 = {1'b0, w[5:1]};
  assign trial = {rem_q[COORD_BITS-1:0], num_q[DIVW-1]};
  assign qmag = num_q[SW-1:0];
  assign sts_o = '{div_done: div_done, last_pix: last_pix, done_flag: done_flag};

  always_comb begin
    unique case (cmd_i.col_sel)
      SEL_FIRST:  ysel = y0f_q;
      SEL_SECOND: ysel = endy_q;
      default:    ysel = yint_q;
    endcase
    base = ysel[YW-1:FRAC_BITS];
    f = ysel[FRAC_BITS-1:0];
    onef = (FRAC_BITS+1)'(1) << FRAC_BITS;
    plo = (FRAC_BITS+10)'(onef - {1'b0, f}) * 8'd255;
    phi = (FRAC_BITS+10)'(f) * 8'd255;
    if (cmd_i.col_half) begin
      plo = plo + (FRAC_BITS+10)'(onef);
      phi = phi + (FRAC_BITS+10)'(onef);
    end else begin
      plo = plo + (FRAC_BITS+10)'(onef >> 1);
      phi = phi + (FRAC_BITS+10)'(onef >> 1);
    end
  end

  always_comb begin
    steep_d = steep_q; colx_d = colx_q; finx_d = finx_q; x0_d = x0_q;
    yint_d = yint_q; endy_d = endy_q; y0f_d = y0f_q; slope_d = slope_q;
    neg_d = neg_q; dx_d = dx_q; num_d = num_q; rem_d = rem_q;
    cnt_d = cnt_q; busy_d = busy_q; pcol_d = pcol_q; perp_d = perp_q;
    lo_d = lo_q; hi_d = hi_q; pidx_d = pidx_q; llast_d = llast_q;
    div_done = 1'b0;
    if (cmd_i.start) begin
      steep_d = stp;
      dx_d = sx1 - sx0;
      neg_d = sy1 < sy0;
      num_d = DIVW'((sy1 < sy0 ? sy0 - sy1 : sy1 - sy0)) << FRAC_BITS;
      rem_d = '0;
      cnt_d = DCW'(DIVW);
      busy_d = 1'b1;
      x0_d = CW'(sx0);
      finx_d = CW'(sx1);
      colx_d = CW'(sx0) + 1'b1;
      y0f_d = YW'(sy0) << FRAC_BITS;
      endy_d = YW'(sy1) << FRAC_BITS;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        div_done = 1'b1;
        if (dx_q == '0) slope_d = SW'(1) << FRAC_BITS;
        else if (rem_q >= {1'b0, dx_q} - {1'b0, dx_q >> 1})
          slope_d = neg_q ? -SW'(qmag + 1'b1) : SW'(qmag + 1'b1);
        else slope_d = neg_q ? -SW'(qmag) : SW'(qmag);
      end else begin
        cnt_d = cnt_q - 1'b1;
        if (trial >= {1'b0, dx_q}) begin
          rem_d = trial - {1'b0, dx_q};
          num_d = {num_q[DIVW-2:0], 1'b1};
        end else begin
          rem_d = trial;
          num_d = {num_q[DIVW-2:0], 1'b0};
        end
      end
    end
    if (div_done) yint_d = y0f_q + YW'(slope_d);
    if (cmd_i.col_start) begin
      unique case (cmd_i.col_sel)
        SEL_FIRST:  pcol_d = x0_q;
        SEL_SECOND: pcol_d = finx_q;
        default: begin
          pcol_d = colx_q;
          colx_d = colx_q + 1'b1;
          yint_d = yint_q + YW'(slope_q);
        end
      endcase
      perp_d = OW'(base) - OW'(off1);
      lo_d = cmd_i.col_half ? plo[FRAC_BITS+8:FRAC_BITS+1] : plo[FRAC_BITS+7:FRAC_BITS];
      hi_d = cmd_i.col_half ? phi[FRAC_BITS+8:FRAC_BITS+1] : phi[FRAC_BITS+7:FRAC_BITS];
      pidx_d = '0;
      llast_d = cmd_i.pix_llast;
    end else if (cmd_i.pix_adv) begin
      // The pixels of a column are contiguous rows, the last one included.
      pidx_d = pidx_q + 1'b1;
      perp_d = perp_q + 1'b1;
    end
  end

  always_comb begin
    logic [CW-1:0] cnext;
    cnext = (cmd_i.col_sel == SEL_SECOND) ? colx_q : colx_q + 1'b1;
    done_flag = cnext >= finx_q;
    last_pix = pidx_q == (w + 6'd1);
  end

  always_comb begin
    logic [7:0] cv;
    logic [13:0] pc;
    if (pidx_q == '0) cv = lo_q;
    else if (pidx_q == w + 6'd1) cv = hi_q;
    else cv = 8'd255;
    pc = OW'(pcol_q);
    pixel_x_o = steep_q ? perp_q : pc;
    pixel_y_o = steep_q ? pc : perp_q;
    coverage_o = cv;
    column_last_o = pidx_q == w + 6'd1;
    line_last_o = (pidx_q == w + 6'd1) && llast_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steep_q <= 1'b0; colx_q <= '0; finx_q <= '0; yint_q <= '0;
      slope_q <= '0; endy_q <= '0; busy_q <= 1'b0; cnt_q <= '0;
      pidx_q <= '0;
    end else begin
      steep_q <= steep_d; colx_q <= colx_d; finx_q <= finx_d; yint_q <= yint_d;
      slope_q <= slope_d; endy_q <= endy_d; busy_q <= busy_d; cnt_q <= cnt_d;
      pidx_q <= pidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q <= x0_d; y0f_q <= y0f_d; neg_q <= neg_d; dx_q <= dx_d;
    num_q <= num_d; rem_q <= rem_d; pcol_q <= pcol_d; perp_q <= perp_d;
    lo_q <= lo_d; hi_q <= hi_d; llast_q <= llast_d;
  end
endmodule

@@ design/walr_ctrl.sv @@
module walr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [48:0]         in_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                out_null_o,
  input  walr_pkg::walr_sts_t sts_i,
  output walr_pkg::walr_cmd_t cmd_o
);
  import walr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_DIV = 5'b00010, S_LOAD = 5'b00100,
    S_EMIT = 5'b01000, S_NULL = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic active_q, active_d, pend_q, pend_d;
  logic [1:0] sel_q, sel_d;
  logic half_q, half_d, acc;

  assign in_ready_o = state_q == S_IDLE;
  assign acc = in_valid_i && in_ready_o;
  assign out_valid_o = state_q == S_EMIT || state_q == S_NULL;
  assign out_null_o = state_q == S_NULL;

  always_comb begin
    state_d = state_q; active_d = active_q; pend_d = pend_q;
    sel_d = sel_q; half_d = half_q;
    cmd_o = '0;
    cmd_o.x0 = in_data_i[12:1]; cmd_o.y0 = in_data_i[24:13];
    cmd_o.x1 = in_data_i[36:25]; cmd_o.y1 = in_data_i[48:37];
    cmd_o.col_sel = sel_q;
    cmd_o.col_half = half_q;
    unique case (state_q)
      S_IDLE: if (acc) begin
        if (!in_data_i[0]) begin
          cmd_o.start = 1'b1;
          state_d = S_DIV;
          active_d = 1'b1; pend_d = 1'b1;
          sel_d = SEL_FIRST; half_d = 1'b1;
        end else if (!active_q) begin
          state_d = S_NULL;
        end else begin
          state_d = S_LOAD;
          if (pend_q) begin
            sel_d = SEL_SECOND; half_d = 1'b1;
          end else begin
            sel_d = SEL_INTERIOR; half_d = 1'b0;
          end
        end
      end
      S_DIV: if (sts_i.div_done) state_d = S_LOAD;
      S_LOAD: begin
        cmd_o.col_start = 1'b1;
        if (sel_q == SEL_SECOND) begin
          pend_d = 1'b0;
          cmd_o.pix_llast = sts_i.done_flag;
          if (sts_i.done_flag) active_d = 1'b0;
        end else if (sel_q == SEL_INTERIOR) begin
          cmd_o.pix_llast = sts_i.done_flag;
          if (sts_i.done_flag) active_d = 1'b0;
        end
        state_d = S_EMIT;
      end
      S_EMIT: if (out_ready_i) begin
        cmd_o.pix_adv = 1'b1;
        if (sts_i.last_pix) state_d = S_IDLE;
      end
      S_NULL: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; active_q <= 1'b0; pend_q <= 1'b0;
      sel_q <= SEL_FIRST; half_q <= 1'b0;
    end else begin
      state_q <= state_d; active_q <= active_d; pend_q <= pend_d;
      sel_q <= sel_d; half_q <= half_d;
    end
  end
endmodule
